@@ rtl/core/ils_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the list store.
package ils_pkg;

  localparam int CAPACITY  = 64;
  localparam int ELEM_BITS = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int OP_BITS   = 3;
  localparam int POS_BITS  = 6;
  localparam int DATA_BITS = 32;
  localparam int S_TDATA_BITS = 40;
  localparam int M_TDATA_BITS = 16;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_FIND    = 3'd4,
    OP_CLEAR   = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_PREV,
    RA_NEXT,
    RA_PTR
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_PTR
  } wr_sel_t;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_t;

  typedef enum logic [1:0] {
    PI_ZERO,
    PI_POS,
    PI_COUNT
  } ptr_sel_t;

  typedef struct packed {
    logic     load;
    logic     ptr_init;
    ptr_sel_t ptr_sel;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    wd_sel_t  wd_sel;
    logic     count_inc;
    logic     count_dec;
    logic     count_clr;
    logic     set_res;
    logic     res_ok;
    logic     res_found;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               full;
    logic               pos_lt_count;
    logic               ptr_eq_pos;
    logic               dn_end;
    logic               scan_end;
    logic               match;
    logic               out_busy;
  } status_t;

endpackage

@@ rtl/core/indexed_list_store.sv @@
// Top level of the indexed list store: stream ports, controller and datapath.
//
// Ordered list of up to 64 elements of 32 bits held in a single-port-write,
// single-port-read memory. Each input item on the s_ channel carries an
// operation (append, insert, remove, replace, find, clear), a position and
// an element; each produces exactly one result item on the m_ channel with
// ok, found_index and the entry count after the operation.
// An item is taken only while the block is idle. Append, replace, clear,
// failed and unused operations finish without a loop; insert below the
// count, remove and find run a shift or scan loop that reads each entry
// through the registered memory read before writing or comparing it.
// The next item may be accepted in the cycle after the result is loaded,
// even while that result still waits in the output register.
// If m_tready is low the result is held; a further finished result waits
// in the controller until the output register empties.
// Reset (rst, synchronous) empties the list and drops any pending result;
// the memory itself is not cleared.
module indexed_list_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [5:0] position, [37:6] element, [39:38] zero
  input  logic [ils_pkg::S_TDATA_BITS-1:0]   s_tdata,
  // [2:0] opcode
  input  logic [ils_pkg::OP_BITS-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] ok, [6:1] found_index, [13:7] count, [15:14] zero
  output logic [ils_pkg::M_TDATA_BITS-1:0]   m_tdata
);

  ils_pkg::cmd_t    cmd;
  ils_pkg::status_t status;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ils_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_op    (s_tuser),
    .in_pos   (s_tdata[ils_pkg::POS_BITS-1:0]),
    .in_elem  (s_tdata[ils_pkg::POS_BITS +: ils_pkg::DATA_BITS]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ rtl/core/ils_ctrl.sv @@
// Sequencer for list operations: issues memory, pointer and count commands.
module ils_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ils_pkg::status_t status,
  output ils_pkg::cmd_t    cmd
);

  ils_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ils_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.ptr_sel = ils_pkg::PI_ZERO;
    cmd.rd_sel  = ils_pkg::RA_PTR;
    cmd.wr_sel  = ils_pkg::WA_PTR;
    cmd.wd_sel  = ils_pkg::WD_VALUE;
    case (state)
      ils_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ils_pkg::S_EXEC;
        end
      end
      ils_pkg::S_EXEC: begin
        cmd.set_res = 1'b1;
        state_next  = ils_pkg::S_DONE;
        case (status.op)
          ils_pkg::OP_APPEND: begin
            if (!status.full) begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = ils_pkg::WA_COUNT;
              cmd.count_inc = 1'b1;
              cmd.res_ok    = 1'b1;
            end
          end
          ils_pkg::OP_INSERT: begin
            if (!status.full) begin
              if (!status.pos_lt_count) begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = ils_pkg::WA_COUNT;
                cmd.count_inc = 1'b1;
                cmd.res_ok    = 1'b1;
              end else begin
                cmd.set_res  = 1'b0;
                cmd.ptr_init = 1'b1;
                cmd.ptr_sel  = ils_pkg::PI_COUNT;
                state_next   = ils_pkg::S_UP_RD;
              end
            end
          end
          ils_pkg::OP_REMOVE: begin
            if (status.pos_lt_count) begin
              cmd.set_res  = 1'b0;
              cmd.ptr_init = 1'b1;
              cmd.ptr_sel  = ils_pkg::PI_POS;
              state_next   = ils_pkg::S_DN_RD;
            end
          end
          ils_pkg::OP_REPLACE: begin
            if (status.pos_lt_count) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ils_pkg::WA_POS;
              cmd.res_ok = 1'b1;
            end
          end
          ils_pkg::OP_FIND: begin
            cmd.set_res  = 1'b0;
            cmd.ptr_init = 1'b1;
            cmd.ptr_sel  = ils_pkg::PI_ZERO;
            state_next   = ils_pkg::S_FIND_RD;
          end
          ils_pkg::OP_CLEAR: begin
            cmd.count_clr = 1'b1;
            cmd.res_ok    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ils_pkg::S_UP_RD: begin
        if (status.ptr_eq_pos) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = ils_pkg::WA_POS;
          cmd.count_inc = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_ok    = 1'b1;
          state_next    = ils_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RA_PREV;
          state_next = ils_pkg::S_UP_WR;
        end
      end
      ils_pkg::S_UP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ils_pkg::WA_PTR;
        cmd.wd_sel  = ils_pkg::WD_RDATA;
        cmd.ptr_dec = 1'b1;
        state_next  = ils_pkg::S_UP_RD;
      end
      ils_pkg::S_DN_RD: begin
        if (status.dn_end) begin
          cmd.count_dec = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_ok    = 1'b1;
          state_next    = ils_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RA_NEXT;
          state_next = ils_pkg::S_DN_WR;
        end
      end
      ils_pkg::S_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ils_pkg::WA_PTR;
        cmd.wd_sel  = ils_pkg::WD_RDATA;
        cmd.ptr_inc = 1'b1;
        state_next  = ils_pkg::S_DN_RD;
      end
      ils_pkg::S_FIND_RD: begin
        if (status.scan_end) begin
          cmd.set_res = 1'b1;
          state_next  = ils_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RA_PTR;
          state_next = ils_pkg::S_FIND_CMP;
        end
      end
      ils_pkg::S_FIND_CMP: begin
        if (status.match) begin
          cmd.set_res   = 1'b1;
          cmd.res_ok    = 1'b1;
          cmd.res_found = 1'b1;
          state_next    = ils_pkg::S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = ils_pkg::S_FIND_RD;
        end
      end
      ils_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ils_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ils_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/ils_datapath.sv @@
// Entry memory, count, scan pointer, operand and result registers of the list store.
module ils_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ils_pkg::cmd_t                     cmd,
  output ils_pkg::status_t                  status,
  input  logic [ils_pkg::OP_BITS-1:0]       in_op,
  input  logic [ils_pkg::POS_BITS-1:0]      in_pos,
  input  logic [ils_pkg::DATA_BITS-1:0]     in_elem,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ils_pkg::M_TDATA_BITS-1:0]  m_tdata
);

  localparam int CW = ils_pkg::CNT_BITS;
  localparam int IW = ils_pkg::IDX_BITS;
  localparam int EW = ils_pkg::ELEM_BITS;
  localparam int PW = ils_pkg::POS_BITS;

  logic [EW-1:0] mem [ils_pkg::CAPACITY];
  logic [EW-1:0] rdata;

  logic [ils_pkg::OP_BITS-1:0] op;
  logic [PW-1:0]               pos;
  logic [EW-1:0]               value;
  logic [CW-1:0]               count;
  logic [CW-1:0]               ptr;
  logic                        res_ok;
  logic [PW-1:0]               res_found;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  assign pos_ext = CW'(pos);

  always_comb begin
    case (cmd.rd_sel)
      ils_pkg::RA_PREV: rd_addr = ptr - CW'(1);
      ils_pkg::RA_NEXT: rd_addr = ptr + CW'(1);
      default:          rd_addr = ptr;
    endcase
    case (cmd.wr_sel)
      ils_pkg::WA_COUNT: wr_addr = count;
      ils_pkg::WA_POS:   wr_addr = pos_ext;
      default:           wr_addr = ptr;
    endcase
    wr_data = (cmd.wd_sel == ils_pkg::WD_RDATA) ? rdata : value;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr[IW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_op;
      pos   <= in_pos;
      value <= in_elem[EW-1:0];
    end
    if (cmd.ptr_init) begin
      case (cmd.ptr_sel)
        ils_pkg::PI_POS:   ptr <= pos_ext;
        ils_pkg::PI_COUNT: ptr <= count;
        default:           ptr <= '0;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CW'(1);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - CW'(1);
    end
    if (cmd.set_res) begin
      res_ok    <= cmd.res_ok;
      res_found <= cmd.res_found ? ptr[PW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_clr) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{(ils_pkg::M_TDATA_BITS - 1 - PW - CW){1'b0}}, count, res_found, res_ok};
    end
  end

  always_comb begin
    status.op           = op;
    status.full         = (count == CW'(ils_pkg::CAPACITY));
    status.pos_lt_count = (pos_ext < count);
    status.ptr_eq_pos   = (ptr == pos_ext);
    status.dn_end       = ((ptr + CW'(1)) >= count);
    status.scan_end     = (ptr >= count);
    status.match        = (rdata == value);
    status.out_busy     = m_tvalid && !m_tready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ils_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.count_inc |-> count < CW'(ils_pkg::CAPACITY))
    else $error("count increment on a full list");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.count_dec |-> count != '0)
    else $error("count decrement on an empty list");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (wr_addr <= count) && (wr_addr < CW'(ils_pkg::CAPACITY)))
    else $error("entry write beyond end of list");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a stalled item");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking stream testbench for the indexed list store.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ils_pkg::OP_BITS-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [ils_pkg::OP_BITS-1:0] OP_UNUSED_7 = 3'd7;
  localparam int PHASES           = 5;
  localparam int PHASE_ITEMS      = 370;
  localparam int MODE_SPAN        = 150;
  localparam int SETTLE_CYCLES    = 150;

  typedef logic [ils_pkg::POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic [1:0]                   pad;
    logic [ils_pkg::CNT_BITS-1:0] count;
    logic [ils_pkg::IDX_BITS-1:0] found_index;
    logic                         ok;
  } list_result_t;

  class list_tracker;
    logic [ils_pkg::ELEM_BITS-1:0] shadow [ils_pkg::CAPACITY];
    int unsigned                   shadow_count = 0;
    list_result_t                  pending_results [$];
    int unsigned                   error_count = 0;

    function bit push(logic [ils_pkg::ELEM_BITS-1:0] value);
      if (shadow_count >= ils_pkg::CAPACITY) return 1'b0;
      shadow[shadow_count] = value;
      shadow_count++;
      return 1'b1;
    endfunction

    function void note_op(logic [ils_pkg::OP_BITS-1:0] op, logic [ils_pkg::POS_BITS-1:0] pos,
                          logic [ils_pkg::DATA_BITS-1:0] elem);
      list_result_t r;
      logic [ils_pkg::ELEM_BITS-1:0] value;
      r = '0;
      value = elem[ils_pkg::ELEM_BITS-1:0];
      case (op)
        ils_pkg::OP_APPEND: r.ok = push(value);
        ils_pkg::OP_INSERT: begin
          if (pos >= shadow_count) begin
            r.ok = push(value);
          end else if (shadow_count < ils_pkg::CAPACITY) begin
            for (int i = shadow_count; i > pos; i--) shadow[i] = shadow[i-1];
            shadow[pos] = value;
            shadow_count++;
            r.ok = 1'b1;
          end
        end
        ils_pkg::OP_REMOVE: begin
          if (pos < shadow_count) begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow[i] = shadow[i+1];
            shadow_count--;
            r.ok = 1'b1;
          end
        end
        ils_pkg::OP_REPLACE: begin
          if (pos < shadow_count) begin
            shadow[pos] = value;
            r.ok = 1'b1;
          end
        end
        ils_pkg::OP_FIND: begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow[i] == value) begin
              r.ok = 1'b1;
              r.found_index = i[ils_pkg::IDX_BITS-1:0];
              break;
            end
          end
        end
        ils_pkg::OP_CLEAR: begin
          shadow_count = 0;
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.count = shadow_count[ils_pkg::CNT_BITS-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok || got.found_index !== want.found_index ||
          got.count !== want.count) begin
        error_count++;
        if (error_count <= 10)
          $display("result mismatch: ok %0b/%0b found_index %0d/%0d count %0d/%0d (exp/act)",
                   want.ok, got.ok, want.found_index, got.found_index,
                   want.count, got.count);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [ils_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
  logic [ils_pkg::OP_BITS-1:0]      s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [ils_pkg::M_TDATA_BITS-1:0] m_tdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // append, insert, remove, replace, find, clear, unused
  int op_weight [3][7] = '{'{35, 38,  6,  6, 12, 0, 3},
                           '{18, 20, 22, 14, 20, 2, 4},
                           '{ 8, 10, 50,  8, 18, 2, 4}};
  logic [ils_pkg::OP_BITS-1:0] op_code [7] = '{ils_pkg::OP_APPEND, ils_pkg::OP_INSERT,
                                               ils_pkg::OP_REMOVE, ils_pkg::OP_REPLACE,
                                               ils_pkg::OP_FIND, ils_pkg::OP_CLEAR,
                                               OP_UNUSED_6};
  int phase_send [PHASES] = '{0, 86,  0, 21, 0};
  int phase_recv [PHASES] = '{0,  0, 86, 21, 0};

  list_tracker tracker;

  indexed_list_store dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  task automatic send_item(input logic [ils_pkg::OP_BITS-1:0] op,
                           input logic [ils_pkg::POS_BITS-1:0] pos,
                           input logic [ils_pkg::DATA_BITS-1:0] elem);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, elem, pos};
    do @(posedge clk); while (!s_tready);
    tracker.note_op(op, pos, elem);
  endtask

  // called right after an acceptance, so at least one result is outstanding
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_item(input int mode);
    logic [ils_pkg::OP_BITS-1:0]   op;
    logic [ils_pkg::POS_BITS-1:0]  pos;
    logic [ils_pkg::DATA_BITS-1:0] elem;
    int r, acc, k, cnt;
    r = $urandom_range(99);
    acc = 0;
    k = 0;
    while (k < 6 && r >= acc + op_weight[mode][k]) begin
      acc += op_weight[mode][k];
      k++;
    end
    op = op_code[k];
    if (k == 6 && $urandom_range(1)) op = OP_UNUSED_7;
    cnt = tracker.shadow_count;
    if (cnt > 0 && $urandom_range(99) < 85)
      pos = pos_t'($urandom_range((op == ils_pkg::OP_INSERT && cnt < ils_pkg::CAPACITY) ?
                                  cnt : cnt - 1));
    else
      pos = pos_t'($urandom);
    r = $urandom_range(99);
    if (cnt > 0 && r < (op == ils_pkg::OP_FIND ? 65 : 25))
      elem = tracker.shadow[$urandom_range(cnt - 1)];
    else if ($urandom_range(99) < 30)
      elem = $urandom_range(7);
    else
      elem = $urandom;
    send_item(op, pos, elem);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_result(list_result_t'(m_tdata));
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, then shifting inserts, duplicates, bounds and unused codes
    send_item(ils_pkg::OP_FIND,     6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_REMOVE,   6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_REPLACE,  6'd0,  32'hFFFF_FFFF);
    send_item(ils_pkg::OP_INSERT,   6'd63, 32'h0000_0001);
    send_item(ils_pkg::OP_APPEND,   6'd0,  32'hFFFF_FFFF);
    send_item(ils_pkg::OP_APPEND,   6'd63, 32'h0000_0000);
    send_item(ils_pkg::OP_INSERT,   6'd0,  32'hA5A5_A5A5);
    send_item(ils_pkg::OP_INSERT,   6'd2,  32'h5A5A_5A5A);
    send_item(ils_pkg::OP_FIND,     6'd0,  32'hFFFF_FFFF);
    send_item(ils_pkg::OP_FIND,     6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_FIND,     6'd0,  32'h1234_5678);
    send_item(ils_pkg::OP_APPEND,   6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_FIND,     6'd63, 32'h0000_0000);
    send_item(ils_pkg::OP_REPLACE,  6'd5,  32'h8000_0000);
    send_item(ils_pkg::OP_REPLACE,  6'd6,  32'h7FFF_FFFF);
    send_item(ils_pkg::OP_REMOVE,   6'd6,  32'h0000_0000);
    send_item(ils_pkg::OP_REMOVE,   6'd5,  32'h0000_0000);
    send_item(ils_pkg::OP_REMOVE,   6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_INSERT,   6'd4,  32'hDEAD_BEEF);
    send_item(OP_UNUSED_6,          6'd63, 32'hFFFF_FFFF);
    send_item(OP_UNUSED_7,          6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_CLEAR,    6'd63, 32'hFFFF_FFFF);
    send_item(ils_pkg::OP_FIND,     6'd0,  32'h0000_0000);
    send_item(ils_pkg::OP_REMOVE,   6'd63, 32'h0000_0000);
    hold_until_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (int n = 0; n < PHASE_ITEMS; n++)
        random_item(((ph * PHASE_ITEMS + n) / MODE_SPAN) % 3);
      hold_until_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.error_count == 0 && tracker.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
